// ===== hdl/zoom_ratio_position_map_macros.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef ZOOM_RATIO_POSITION_MAP_MACROS_SVH
`define ZOOM_RATIO_POSITION_MAP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define ZRPM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define ZRPM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/zrpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zrpm_pkg;

    localparam int RATIO_FRAC_BITS = 8;
    localparam int TABLE_POINTS    = 30;
    localparam int TABLE_LEN       = 30;
    localparam int N_PTS           = (TABLE_POINTS < TABLE_LEN) ? TABLE_POINTS : TABLE_LEN;
    localparam int IDX_W           = $clog2(N_PTS);
    localparam int DIGITAL_STEPS   = 11;

    localparam int POS_W   = 16;
    localparam int RATIO_W = 17;

    // 11 * max optical ratio
    localparam int DEN_W  = RATIO_W + 4;
    // divisor: twice the span denominator
    localparam int D_W    = DEN_W + 1;
    // dividend: 22 * ratio * position span plus rounding term
    localparam int X_W    = 38;
    localparam int MA_W   = D_W + 1;
    localparam int MB_W   = RATIO_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int MAG_W  = X_W + 1;
    localparam int DIV_CNT_W = $clog2(X_W);

    localparam int RATIO_HALF = 1 << (RATIO_FRAC_BITS - 1);

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << RATIO_FRAC_BITS);

    localparam logic OP_R2P = 1'b0;
    localparam logic OP_P2R = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_END    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTICAL_END = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPTICAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITAL = 3'd4;

    // lens position at 1x, 2x, ... 30x
    localparam logic [POS_W-1:0] LENS_POINTS [TABLE_LEN] = '{
        16'h0000, 16'h16A1, 16'h2063, 16'h2628, 16'h2A1D, 16'h2D13,
        16'h2F6D, 16'h3161, 16'h330D, 16'h3486, 16'h35D7, 16'h3709,
        16'h3820, 16'h3920, 16'h3A0A, 16'h3ADD, 16'h3B9C, 16'h3C46,
        16'h3CDC, 16'h3D60, 16'h3DD4, 16'h3E39, 16'h3E90, 16'h3EDC,
        16'h3F1E, 16'h3F57, 16'h3F8A, 16'h3FB6, 16'h3FDC, 16'h4000
    };

    function automatic logic [POS_W-1:0] lens_point(input logic [IDX_W-1:0] idx);
        logic [POS_W-1:0] v;
        v = '0;
        if (int'(idx) < TABLE_LEN) begin
            v = LENS_POINTS[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/zrpm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "zoom_ratio_position_map_macros.svh"

module zrpm_div
    import zrpm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [X_W-1:0]   i_dividend,
    input  wire logic [D_W-1:0]   i_divisor,
    output logic                  o_done,
    output logic [X_W-1:0]        o_quot
);

    logic [X_W-1:0]       r_quot, n_quot;
    logic [D_W-1:0]       r_rem, n_rem;
    logic [D_W-1:0]       r_dvs, n_dvs;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [D_W:0]         trial;
    logic                 ge;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial  = {r_rem, r_quot[X_W-1]};
        ge     = (trial >= {1'b0, r_dvs});
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(X_W - 1);
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = ge ? D_W'(trial - {1'b0, r_dvs}) : trial[D_W-1:0];
            n_quot = {r_quot[X_W-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `ZRPM_ASSERT_IMP(a_rem_below_divisor, r_busy, r_rem < r_dvs, "partial remainder not below divisor")
    `ZRPM_ASSERT_NXT(a_start_takes, i_start && !r_busy, r_busy, "divider did not start")
    `ZRPM_ASSERT_NXT(a_done_single, r_done, !r_done && !r_busy, "done not a single idle pulse")

endmodule

`default_nettype wire

// ===== hdl/zoom_ratio_position_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "zoom_ratio_position_map_macros.svh"

// Zoom ratio <-> lens position converter. Pulse start while busy is low to hand
// over one command; busy stays high until the result is out. The result shows
// on o_position_out / o_ratio_out for exactly one cycle with o_done high and
// cannot be held off, so capture it on that cycle. Each command passes the clamp
// and select states and then, as needed: no arithmetic (zero optical maximum,
// empty digital span), a multiply and the 38-step restoring divider for the
// digital span, a segment scan of up to 29 steps plus multiply for table
// ratio-to-position, and a segment scan followed where needed by the divider for
// table position-to-ratio, before the finish state. busy drops in the o_done
// cycle, so the next command can be taken there. Configuration writes are always
// ready and must only be issued while busy is low.
module zoom_ratio_position_map
    import zrpm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_operation,
    input  wire logic [RATIO_W-1:0]   i_ratio_in,
    input  wire logic [POS_W-1:0]     i_position_in,
    output logic                      o_done,
    output logic [POS_W-1:0]          o_position_out,
    output logic [RATIO_W-1:0]        o_ratio_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RATIO_W-1:0]   i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLAMP = 9'b000000010,
        S_SEL   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_PREP  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_ADJ   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [POS_W-1:0]   r_we, r_ot, r_dt;
    logic [RATIO_W-1:0] r_mo, r_md;

    logic                     r_op, n_op;
    logic [RATIO_W-1:0]       r_val, n_val;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_dig, n_dig;
    logic                     r_neg, n_neg;
    logic [RATIO_W-1:0]       r_base, n_base;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic [DEN_W-1:0]         r_den, n_den;
    logic signed [MA_W-1:0]   r_ma, n_ma;
    logic signed [MB_W-1:0]   r_mb, n_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic [X_W-1:0]           r_dvd, n_dvd;
    logic [D_W-1:0]           r_dvs, n_dvs;
    logic                     r_go, n_go;
    logic                     r_valid, n_valid;
    logic [POS_W-1:0]         r_pos_out, n_pos_out;
    logic [RATIO_W-1:0]       r_ratio_out, n_ratio_out;

    logic                     div_done;
    logic [X_W-1:0]           div_quot;

    logic [POS_W-1:0]         hi_p, lo_p, seg_d;
    logic [RATIO_W-1:0]       hi_r, lo_r, clamp_t;
    logic [POS_W-1:0]         clamp_p;
    logic                     hit;
    logic signed [PROD_W:0]   x_d0;
    logic [X_W-1:0]           x_d1;
    logic [PROD_W-1:0]        t0_sum;
    logic [MAG_W:0]           sum_fin;
    logic [RATIO_W-1:0]       lim, res;

    zrpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        hi_p    = lens_point(r_idx);
        lo_p    = lens_point(r_idx - 1'b1);
        seg_d   = hi_p - lo_p;
        hi_r    = RATIO_W'((32'(r_idx) + 1) << RATIO_FRAC_BITS);
        lo_r    = RATIO_W'(32'(r_idx) << RATIO_FRAC_BITS);
        hit     = (r_op == OP_R2P) ? (r_val <= hi_r) : (r_val[POS_W-1:0] <= hi_p);
        x_d0    = $signed({r_prod, 1'b0}) + $signed({(PROD_W + 1 - DEN_W)'(0), r_den});
        x_d1    = r_prod[X_W-1:0] + X_W'(r_den);
        t0_sum  = $unsigned(r_prod) + PROD_W'(RATIO_HALF);
        sum_fin = (MAG_W + 1)'(r_mag) + (MAG_W + 1)'(r_base);
        lim     = (r_op == OP_R2P) ? RATIO_W'(POS_MAX) : RATIO_MAX;
        clamp_t = (r_val > r_md) ? r_md : r_val;
        clamp_p = (r_val[POS_W-1:0] > r_dt) ? r_dt : r_val[POS_W-1:0];
        if (r_neg) begin
            res = (r_mag > MAG_W'(r_base)) ? '0 : RATIO_W'(MAG_W'(r_base) - r_mag);
        end else begin
            res = (sum_fin > (MAG_W + 1)'(lim)) ? lim : RATIO_W'(sum_fin);
        end

        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_idx       = r_idx;
        n_dig       = r_dig;
        n_neg       = r_neg;
        n_base      = r_base;
        n_mag       = r_mag;
        n_den       = r_den;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_go        = 1'b0;
        n_valid     = 1'b0;
        n_pos_out   = r_pos_out;
        n_ratio_out = r_ratio_out;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_val   = (i_operation == OP_R2P) ? i_ratio_in : RATIO_W'(i_position_in);
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (r_op == OP_R2P) begin
                    n_val = (clamp_t < RATIO_ONE) ? RATIO_ONE : clamp_t;
                end else begin
                    n_val = RATIO_W'((clamp_p < r_we) ? r_we : clamp_p);
                end
                n_state = S_SEL;
            end
            S_SEL: begin
                n_neg = 1'b0;
                n_mag = '0;
                n_idx = IDX_W'(1);
                n_dig = 1'b0;
                if (r_op == OP_R2P) begin
                    if (r_val > r_mo) begin
                        if (r_mo == '0) begin
                            n_base  = RATIO_W'(r_dt);
                            n_state = S_FIN;
                        end else begin
                            n_den   = DEN_W'(r_mo) * DEN_W'(DIGITAL_STEPS);
                            n_ma    = MA_W'(r_val - r_mo);
                            n_mb    = MB_W'($signed({1'b0, r_dt}) - $signed({1'b0, r_ot}));
                            n_dig   = 1'b1;
                            n_state = S_MUL;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    if (r_val[POS_W-1:0] > r_ot) begin
                        if (r_dt <= r_ot) begin
                            n_base  = '0;
                            n_mag   = MAG_W'(r_mo) * MAG_W'(DIGITAL_STEPS + 1);
                            n_state = S_FIN;
                        end else begin
                            n_den   = DEN_W'(r_dt - r_ot);
                            n_ma    = MA_W'(r_mo) * MA_W'(2 * DIGITAL_STEPS);
                            n_mb    = MB_W'(r_val[POS_W-1:0] - r_ot);
                            n_dig   = 1'b1;
                            n_state = S_MUL;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_op == OP_R2P) begin
                        n_base  = RATIO_W'(lo_p);
                        n_ma    = MA_W'(r_val - lo_r);
                        n_mb    = MB_W'(seg_d);
                        n_state = S_MUL;
                    end else if (hi_p <= lo_p || r_val[POS_W-1:0] < lo_p) begin
                        n_base  = lo_r;
                        n_state = S_FIN;
                    end else begin
                        n_dvd   = (X_W'(r_val[POS_W-1:0] - lo_p) << (RATIO_FRAC_BITS + 1))
                                + X_W'(seg_d);
                        n_dvs   = D_W'(seg_d) << 1;
                        n_base  = lo_r;
                        n_go    = 1'b1;
                        n_state = S_DIV;
                    end
                end else if (r_idx == IDX_W'(N_PTS - 1)) begin
                    n_base  = (r_op == OP_R2P) ? RATIO_W'(r_ot) : r_mo;
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                if (r_op == OP_R2P && !r_dig) begin
                    n_mag   = MAG_W'(t0_sum >> RATIO_FRAC_BITS);
                    n_state = S_FIN;
                end else if (r_op == OP_R2P) begin
                    // negative sums divide the ones' complement; quotient is then -(q + 1)
                    n_neg   = x_d0[PROD_W];
                    n_dvd   = x_d0[PROD_W] ? ~x_d0[X_W-1:0] : x_d0[X_W-1:0];
                    n_dvs   = D_W'(r_den) << 1;
                    n_base  = RATIO_W'(r_ot);
                    n_go    = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_dvd   = x_d1;
                    n_dvs   = D_W'(r_den) << 1;
                    n_base  = r_mo;
                    n_go    = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                n_mag   = MAG_W'(div_quot) + MAG_W'(r_neg);
                n_state = S_FIN;
            end
            S_FIN: begin
                n_valid     = 1'b1;
                n_pos_out   = (r_op == OP_R2P) ? res[POS_W-1:0] : '0;
                n_ratio_out = (r_op == OP_R2P) ? '0 : res;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            r_we    <= 16'd0;
            r_ot    <= 16'd16384;
            r_dt    <= 16'd31424;
            r_mo    <= 17'd7680;
            r_md    <= 17'd92160;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= n_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDE_END:    r_we <= i_cfg_data[POS_W-1:0];
                    CFG_OPTICAL_END: r_ot <= i_cfg_data[POS_W-1:0];
                    CFG_DIGITAL_END: r_dt <= i_cfg_data[POS_W-1:0];
                    CFG_MAX_OPTICAL: r_mo <= i_cfg_data;
                    CFG_MAX_DIGITAL: r_md <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_op        <= n_op;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_dig       <= n_dig;
        r_neg       <= n_neg;
        r_base      <= n_base;
        r_mag       <= n_mag;
        r_den       <= n_den;
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_prod      <= r_ma * r_mb;
        r_dvd       <= n_dvd;
        r_dvs       <= n_dvs;
        r_pos_out   <= n_pos_out;
        r_ratio_out <= n_ratio_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_valid;
    assign o_position_out = r_pos_out;
    assign o_ratio_out    = r_ratio_out;
    assign o_cfg_ready    = 1'b1;

    `ZRPM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "command transfer did not raise busy")
    `ZRPM_ASSERT_IMP(a_div_done_waiting, div_done, r_state == S_DIV, "divider done outside wait")
    `ZRPM_ASSERT_IMP(a_single_field, o_done && r_op == OP_R2P, o_ratio_out == '0, "ratio set on position result")

endmodule

`default_nettype wire
